// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  // Queue size and field widths
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PRIO_W     = 8;
  localparam int BYTES_W    = 3;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request operation codes
  localparam op_t OP_PUSH  = OP_W'(0);
  localparam op_t OP_POP   = OP_W'(1);
  localparam op_t OP_CLEAR = OP_W'(2);

  // Result status codes
  localparam status_t ST_DONE  = STATUS_W'(0);
  localparam status_t ST_FULL  = STATUS_W'(1);
  localparam status_t ST_EMPTY = STATUS_W'(2);

  // One stored entry
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_WIDTH-1:0]    data;
    logic [BYTES_W-1:0]       bytes;
  } entry_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t new_ent;
  } cell_ctrl_t;

endpackage

// ===== hdl/spq_in_if.sv =====
interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [PRIO_W-1:0] priority_req;
  logic [DATA_WIDTH-1:0]    payload;
  logic [BYTES_W-1:0]       payload_bytes;

  modport source (
    output valid, operation, priority_req, payload, payload_bytes,
    input  ready
  );

  modport sink (
    input  valid, operation, priority_req, payload, payload_bytes,
    output ready
  );

endinterface

// ===== hdl/spq_out_if.sv =====
interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [PRIO_W-1:0] out_priority;
  logic [DATA_WIDTH-1:0]    out_payload;
  logic [BYTES_W-1:0]       out_bytes;
  logic                     head_valid;
  logic signed [PRIO_W-1:0] head_priority;
  logic [DATA_WIDTH-1:0]    head_payload;
  logic [BYTES_W-1:0]       head_bytes;
  logic [TOTAL_W-1:0]       entry_total;

  modport source (
    output valid, status, out_priority, out_payload, out_bytes,
           head_valid, head_priority, head_payload, head_bytes, entry_total,
    input  ready
  );

  modport sink (
    input  valid, status, out_priority, out_payload, out_bytes,
           head_valid, head_priority, head_payload, head_bytes, entry_total,
    output ready
  );

endinterface

// ===== hdl/stable_priority_queue.sv =====
// A result is registered when its request is accepted.
// Throughput: one request per cycle unless a result stalls; the whole cell
// row moves in that cycle. A new request is taken while the previous result
// waits, if the output register empties in the same cycle.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; stored entry contents are left as they are.
module stable_priority_queue (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_if,
  spq_out_if.source out_if
);
  import spq_pkg::*;

  logic              accept;
  logic              push_ok;
  logic              pop_ok;
  logic              clr;
  logic              full;
  logic              empty;
  status_t           status_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  cell_ctrl_t        ctrl;
  entry_t            cell_ent [DEPTH];
  entry_t            cell_nxt [DEPTH];
  logic [DEPTH-1:0]  keep;
  logic              out_valid_r;
  status_t           status_r;
  entry_t            popped_r;
  entry_t            head_r;
  logic              head_valid_r;
  logic [CNT_W-1:0]  total_r;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  // Decode the request
  always_comb begin
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    clr        = 1'b0;
    status_nxt = ST_DONE;
    unique case (in_if.operation)
      OP_PUSH: begin
        push_ok    = accept && !full;
        status_nxt = full ? ST_FULL : ST_DONE;
      end
      OP_POP: begin
        pop_ok     = accept && !empty;
        status_nxt = empty ? ST_EMPTY : ST_DONE;
      end
      OP_CLEAR: begin
        clr = accept;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  assign ctrl.push          = push_ok;
  assign ctrl.pop           = pop_ok;
  assign ctrl.new_ent.prio  = in_if.priority_req;
  assign ctrl.new_ent.data  = in_if.payload;
  assign ctrl.new_ent.bytes = in_if.payload_bytes;

  // Row of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_keep;
    entry_t left_ent;
    entry_t right_ent;
    logic   occupied;

    assign occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_ent  = ctrl.new_ent;
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_ent  = cell_ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occupied),
      .left_keep (left_keep),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .keep      (keep[i]),
      .ent_r     (cell_ent[i]),
      .ent_nxt   (cell_nxt[i])
    );
  end

  // Advance the entry count
  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (push_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      popped_r     <= pop_ok ? cell_ent[0] : '0;
      head_valid_r <= (count_nxt != '0);
      head_r       <= (count_nxt != '0) ? cell_nxt[0] : '0;
      total_r      <= count_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = status_r;
  assign out_if.out_priority  = popped_r.prio;
  assign out_if.out_payload   = popped_r.data;
  assign out_if.out_bytes     = popped_r.bytes;
  assign out_if.head_valid    = head_valid_r;
  assign out_if.head_priority = head_r.prio;
  assign out_if.head_payload  = head_r.data;
  assign out_if.head_bytes    = head_r.bytes;
  assign out_if.entry_total   = TOTAL_W'(total_r);

endmodule

// ===== hdl/spq_cell.sv =====
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                left_keep,
  input  spq_pkg::entry_t     left_ent,
  input  spq_pkg::entry_t     right_ent,
  output logic                keep,
  output spq_pkg::entry_t     ent_r,
  output spq_pkg::entry_t     ent_nxt
);
  import spq_pkg::*;

  // Stay put on a push when holding a priority not above the new one
  assign keep = occupied && ($signed(ent_r.prio) <= $signed(ctrl.new_ent.prio));

  // Hold, take the new entry, shift right on push, shift left on pop
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.push) begin
      if (keep) begin
        ent_nxt = ent_r;
      end else if (left_keep) begin
        ent_nxt = ctrl.new_ent;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (ctrl.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hdl/spq_checker.sv =====
module spq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::BYTES_W-1:0]  out_bytes,
  input logic                         head_valid,
  input logic [spq_pkg::TOTAL_W-1:0]  entry_total
);
  import spq_pkg::*;

  // Stalled result stays presented
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Head flag tracks the count
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head_valid == (entry_total != '0)))
    else $error("head flag disagrees with entry count");

  // Refused push only when full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |-> (entry_total == TOTAL_W'(DEPTH)))
    else $error("push refused below capacity");

  // Refused pop only when empty, returns nothing
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY) |-> (entry_total == '0) && (out_bytes == '0))
    else $error("pop refused with entries present");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .status      (out_if.status),
  .out_bytes   (out_if.out_bytes),
  .head_valid  (out_if.head_valid),
  .entry_total (out_if.entry_total)
);
